/* hdl/cede_pkg.sv */
// ----------------------------------------------------------------------------
// cede_pkg
// Shared types, constants and helpers for the column expression date unit.
// ----------------------------------------------------------------------------
package cede_pkg;

	// expression kind codes, the values held by the kind register
	localparam logic [2:0] KIND_IDENT   = 3'd0;
	localparam logic [2:0] KIND_YEAR    = 3'd1;
	localparam logic [2:0] KIND_MONTH   = 3'd2;
	localparam logic [2:0] KIND_ADD     = 3'd3;
	localparam logic [2:0] KIND_UNKNOWN = 3'd4;

	// configuration register indexes
	localparam logic REG_EXPR_KIND = 1'b0;
	localparam logic REG_ADDEND    = 1'b1;

	// field widths
	localparam int VAL_W  = 64;
	localparam int KIND_W = 3;
	localparam int DOE_W  = 18;
	localparam int QUO_W  = 32;

	// calendar constants
	localparam int ERA_DAYS     = 146097;
	localparam int EPOCH_SHIFT  = 719468;
	localparam int LAST_DOE     = 146096;

	// long division of the biased day count by the era length in 14-bit digits;
	// the top bits above the digits are already smaller than one era
	localparam int DIGIT_W    = 14;
	localparam int DIV_STAGES = 4;
	localparam int DIV_BITS   = DIGIT_W * DIV_STAGES;
	localparam int TRIAL_W    = DOE_W + DIGIT_W;
	localparam int BIASED_W   = VAL_W + 1;

	// reciprocal of the era length, exact for every trial below 146097 * 2^14
	localparam int ERA_SHIFT = 49;
	localparam logic [TRIAL_W-1:0] ERA_RECIP =
		TRIAL_W'(((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097);

	// enough whole eras to lift the most negative day count above zero
	localparam logic [BIASED_W-1:0] ERA_BIAS =
		(65'd1 << 63) / 65'd146097 + 65'd1;
	localparam logic [BIASED_W-1:0] DAY_BIAS =
		ERA_BIAS * 65'd146097 + 65'd719468;
	localparam logic [QUO_W-1:0] ERA_BIAS_LO = ERA_BIAS[QUO_W-1:0];

	// reciprocals for exact division of small values by constants
	localparam int RECIP_SHIFT = 40;
	localparam logic [35:0] RECIP_1460  = 36'(((64'd1 << 40) + 64'd1459) / 64'd1460);
	localparam logic [35:0] RECIP_36524 = 36'(((64'd1 << 40) + 64'd36523) / 64'd36524);
	localparam logic [35:0] RECIP_365   = 36'(((64'd1 << 40) + 64'd364) / 64'd365);
	localparam logic [35:0] RECIP_100   = 36'(((64'd1 << 40) + 64'd99) / 64'd100);
	localparam logic [35:0] RECIP_153   = 36'(((64'd1 << 40) + 64'd152) / 64'd153);

	// one division pipeline slot
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              ok;
		logic [VAL_W-1:0]  res;
		logic [DIV_BITS-1:0] num;
		logic [DOE_W-1:0]  rem;
		logic [QUO_W-1:0]  quo;
	} div_data_t;

	// fields carried alongside the calendar stages
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              ok;
		logic [VAL_W-1:0]  res;
	} carry_t;

	// quotient of an 18-bit value by a constant, exact for this value range
	function automatic logic [13:0] div_recip(input logic [DOE_W-1:0] x,
			input logic [35:0] m);
		logic [53:0] p;
		p = 54'(x) * 54'(m);
		return p[53:RECIP_SHIFT];
	endfunction

endpackage

/* hdl/cede_div_stage.sv */
// ----------------------------------------------------------------------------
// cede_div_stage
// One digit of the era division over two register stages: the quotient digit
// by reciprocal multiplication, then the partial remainder.
// ----------------------------------------------------------------------------
module cede_div_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  cede_pkg::div_data_t  in_data,
	output logic                 out_valid,
	output cede_pkg::div_data_t  out_data
);
	import cede_pkg::*;

	logic [TRIAL_W-1:0]   trial;
	logic [2*TRIAL_W-1:0] recip_prod;
	logic [DIGIT_W-1:0]   digit_c;
	logic [TRIAL_W-1:0]   rem_next;
	div_data_t            shifted_data;
	div_data_t            next_data;

	logic                 valid_s1, valid_s2;
	div_data_t            data_s1, data_s2;
	logic [TRIAL_W-1:0]   trial_s1;
	logic [DIGIT_W-1:0]   digit_s1;

	// bring down the next dividend digit and estimate its quotient digit
	assign trial      = {in_data.rem, in_data.num[DIV_BITS-1 -: DIGIT_W]};
	assign recip_prod = (2*TRIAL_W)'(trial) * (2*TRIAL_W)'(ERA_RECIP);
	assign digit_c    = recip_prod[ERA_SHIFT +: DIGIT_W];

	always_comb begin
		shifted_data     = in_data;
		shifted_data.num = {in_data.num[DIV_BITS-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
	end

	// partial remainder and quotient digit shifted in
	assign rem_next = trial_s1 - TRIAL_W'(digit_s1) * TRIAL_W'(ERA_DAYS);

	always_comb begin
		next_data     = data_s1;
		next_data.rem = rem_next[DOE_W-1:0];
		next_data.quo = {data_s1.quo[QUO_W-DIGIT_W-1:0], digit_s1};
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		data_s1  <= shifted_data;
		trial_s1 <= trial;
		digit_s1 <= digit_c;
		data_s2  <= next_data;
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

/* hdl/column_expr_date_eval_unit.sv */
// ----------------------------------------------------------------------------
// column_expr_date_eval_unit
// Evaluates one configured expression on a stream of signed 64-bit values.
// ----------------------------------------------------------------------------
// A transaction is taken in every cycle that start is high; busy is always
// low. Each result appears on value_out and ok with done high for one cycle,
// in order, for every kind. The pipeline depth is set by the division of
// the day count by the 146097-day era: after the input register, a long
// division in 14-bit digits, four digits of two stages each (a reciprocal
// multiply for the quotient digit, then the remainder), followed by four
// calendar stages and the output register. The receiver cannot stall the
// block. Write expr_kind and addend only while no transaction is in flight.
module column_expr_date_eval_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [63:0] cfg_wdata,
	// command
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value_in,
	// result
	output logic        done,
	output logic [63:0] value_out,
	output logic        ok
);
	import cede_pkg::*;

	logic [KIND_W-1:0]   kind_q;
	logic [VAL_W-1:0]    addend_q;

	logic [BIASED_W-1:0] day_biased;
	div_data_t           entry_data;

	logic                div_valid [0:DIV_STAGES];
	div_data_t           div_data  [0:DIV_STAGES];

	// calendar stages
	logic                valid_s10, valid_s11, valid_s12, valid_s13, valid_s14;
	carry_t              carry_s10, carry_s11, carry_s12, carry_s13;
	logic [DOE_W-1:0]    doe_s10, doe_s11;
	logic [QUO_W-1:0]    era_s10;
	logic [6:0]          c1460_s10;
	logic [2:0]          c36524_s10;
	logic                c146096_s10;
	logic [8:0]          yoe_s11, yoe_s12;
	logic [QUO_W-1:0]    era400_s11, era400_s12;
	logic [8:0]          doy_s12;
	logic [3:0]          month_s13;
	logic [QUO_W-1:0]    year_s13;
	logic [VAL_W-1:0]    value_s14;
	logic                ok_s14;

	logic [DOE_W-1:0]    doe_div;
	logic [13:0]         q1460, q36524, q365, q100, q153;
	logic [DOE_W-1:0]    yoe_num;
	logic [DOE_W-1:0]    yoe_ext;
	logic [DOE_W-1:0]    doy_full;
	logic [DOE_W-1:0]    mp_num;
	logic [3:0]          mp;
	logic [3:0]          month_c;
	logic [QUO_W-1:0]    year_c;
	logic [VAL_W-1:0]    value_c;

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_UNKNOWN;
			addend_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_EXPR_KIND: kind_q   <= cfg_wdata[KIND_W-1:0];
				REG_ADDEND:    addend_q <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// entry: bias the day count, settle the non-date results
	assign day_biased = {value_in[VAL_W-1], value_in} + DAY_BIAS;

	always_comb begin
		entry_data      = '0;
		entry_data.kind = kind_q;
		entry_data.num  = day_biased[DIV_BITS-1:0];
		entry_data.rem  = DOE_W'(day_biased[BIASED_W-1:DIV_BITS]);
		case (kind_q)
			KIND_IDENT: begin
				entry_data.ok  = 1'b1;
				entry_data.res = value_in;
			end
			KIND_ADD: begin
				entry_data.ok  = 1'b1;
				entry_data.res = value_in + addend_q;
			end
			KIND_YEAR, KIND_MONTH: begin
				entry_data.ok  = 1'b1;
				entry_data.res = '0;
			end
			default: begin
				entry_data.ok  = 1'b0;
				entry_data.res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_valid[0] <= 1'b0;
		end else begin
			div_valid[0] <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		div_data[0] <= entry_data;
	end

	// era division digits
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		cede_div_stage u_div_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[g]),
			.in_data   (div_data[g]),
			.out_valid (div_valid[g+1]),
			.out_data  (div_data[g+1])
		);
	end

	// day of era terms and era number
	assign doe_div = div_data[DIV_STAGES].rem;
	assign q1460   = div_recip(doe_div, RECIP_1460);
	assign q36524  = div_recip(doe_div, RECIP_36524);

	// year of era
	assign yoe_num = doe_s10 - DOE_W'(c1460_s10) + DOE_W'(c36524_s10)
		- DOE_W'(c146096_s10);
	assign q365    = div_recip(yoe_num, RECIP_365);

	// day of year
	assign yoe_ext  = DOE_W'(yoe_s11);
	assign q100     = div_recip(yoe_ext, RECIP_100);
	assign doy_full = doe_s11 - (yoe_ext * DOE_W'(365) + (yoe_ext >> 2)
		- DOE_W'(q100));

	// month and year
	assign mp_num  = DOE_W'(doy_s12) * DOE_W'(5) + DOE_W'(2);
	assign q153    = div_recip(mp_num, RECIP_153);
	assign mp      = q153[3:0];
	assign month_c = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
	assign year_c  = QUO_W'(yoe_s12) + era400_s12 + QUO_W'(month_c <= 4'd2);

	// result select
	always_comb begin
		case (carry_s13.kind)
			KIND_YEAR:  value_c = {{(VAL_W-QUO_W){year_s13[QUO_W-1]}}, year_s13};
			KIND_MONTH: value_c = VAL_W'(month_s13);
			default:    value_c = carry_s13.res;
		endcase
	end

	// valid bits of the calendar stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			valid_s14 <= 1'b0;
		end else begin
			valid_s10 <= div_valid[DIV_STAGES];
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
			valid_s14 <= valid_s13;
		end
	end

	// calendar stage payloads
	always_ff @(posedge clk) begin
		carry_s10.kind <= div_data[DIV_STAGES].kind;
		carry_s10.ok   <= div_data[DIV_STAGES].ok;
		carry_s10.res  <= div_data[DIV_STAGES].res;
		doe_s10        <= doe_div;
		era_s10        <= div_data[DIV_STAGES].quo - ERA_BIAS_LO;
		c1460_s10      <= q1460[6:0];
		c36524_s10     <= q36524[2:0];
		c146096_s10    <= (doe_div == DOE_W'(LAST_DOE));

		carry_s11      <= carry_s10;
		doe_s11        <= doe_s10;
		yoe_s11        <= q365[8:0];
		era400_s11     <= era_s10 * QUO_W'(400);

		carry_s12      <= carry_s11;
		doy_s12        <= doy_full[8:0];
		yoe_s12        <= yoe_s11;
		era400_s12     <= era400_s11;

		carry_s13      <= carry_s12;
		month_s13      <= month_c;
		year_s13       <= year_c;

		value_s14      <= value_c;
		ok_s14         <= carry_s13.ok;
	end

	assign done      = valid_s14;
	assign value_out = value_s14;
	assign ok        = ok_s14;

endmodule
